// ----- hw/rtl/watchdog_and_cycle_latch_defines.svh -----
// Assertion macros shared by the watchdog block.
`ifndef WATCHDOG_AND_CYCLE_LATCH_DEFINES_SVH
`define WATCHDOG_AND_CYCLE_LATCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WDCL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WDCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wdcl_pkg.sv -----
package wdcl_pkg;

    // Kind of item on the input channel.
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

    // Low two offset bits that carry a command when the latch bit is clear.
    typedef enum logic [1:0] {
        SUB_STOP  = 2'd0,
        SUB_START = 2'd3
    } t_sub;

    // Offset bit that selects the cycle-count latch bytes.
    localparam int LATCH_BIT = 2;

    // Values of window byte 0.
    localparam logic [7:0] RUN_MARK  = 8'h80;
    localparam logic [7:0] STOP_MARK = 8'h00;

    localparam int WIN_DEPTH   = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int WDOG_WIDTH  = 24;

endpackage

// ----- hw/rtl/watchdog_and_cycle_latch.sv -----
// Watchdog timer with a cycle-count latch behind an 8-byte register window.
// Path from input transfer to result transfer: input register, then result register; one item per
// cycle sustained while results are taken, set by the single update stage.
// Both stages advance while the result register is empty or being taken.
// Reset (i_rst_n low, synchronous) clears the window, counters and both valid flags.
`include "watchdog_and_cycle_latch_defines.svh"

module watchdog_and_cycle_latch (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [2:0] i_offset,
    input  logic [7:0] i_write_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_byte,
    output logic       o_expired,
    output logic       o_running
);

    // Input register stage.
    logic                r_in_valid;
    wdcl_pkg::t_mode     r_in_mode;
    logic [2:0]          r_in_off;
    logic [7:0]          r_in_byte;

    // Block state.
    logic [7:0] r_window [wdcl_pkg::WIN_DEPTH];
    logic [7:0] n_window [wdcl_pkg::WIN_DEPTH];
    logic [wdcl_pkg::COUNT_WIDTH-1:0] r_cycle_count, n_cycle_count;
    logic [wdcl_pkg::WDOG_WIDTH-1:0]  r_reload, n_reload;
    logic [wdcl_pkg::WDOG_WIDTH-1:0]  r_remaining, n_remaining;
    logic                             r_armed, n_armed;

    // Result register stage.
    logic       r_out_valid;
    logic [7:0] r_read_byte, n_read_byte;
    logic       r_expired, n_expired;
    logic       r_running;

    logic out_free;
    logic proc_fire;

    // Handshake: the update stage fires when the result register can take a result.
    assign out_free  = !r_out_valid || i_ready;
    assign proc_fire = r_in_valid && out_free;
    assign o_ready   = !r_in_valid || proc_fire;

    // Capture the input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_mode <= wdcl_pkg::t_mode'(i_mode);
            r_in_off  <= i_offset;
            r_in_byte <= i_write_byte;
        end
    end

    // Next state and result of the item held in the input register.
    always_comb begin
        n_window      = r_window;
        n_cycle_count = r_cycle_count;
        n_reload      = r_reload;
        n_remaining   = r_remaining;
        n_armed       = r_armed;
        n_read_byte   = 8'h00;
        n_expired     = 1'b0;
        case (r_in_mode)
            wdcl_pkg::MODE_TICK: begin
                n_cycle_count = r_cycle_count + 1'b1;
                if (r_armed) begin
                    // A count of zero or one elapses on this tick.
                    if (r_remaining[wdcl_pkg::WDOG_WIDTH-1:1] == '0) begin
                        n_expired   = 1'b1;
                        n_armed     = 1'b0;
                        n_remaining = '0;
                    end else begin
                        n_remaining = r_remaining - 1'b1;
                    end
                end
            end
            wdcl_pkg::MODE_READ: begin
                n_read_byte = r_window[r_in_off];
                // Reading a control byte retriggers a running countdown.
                if (!r_in_off[wdcl_pkg::LATCH_BIT] && r_armed) begin
                    n_remaining = r_reload;
                end
            end
            wdcl_pkg::MODE_WRITE: begin
                n_window[r_in_off] = r_in_byte;
                if (r_in_off[wdcl_pkg::LATCH_BIT]) begin
                    // Latch the cycle count, little endian, into bytes 4 to 7.
                    n_window[4] = r_cycle_count[7:0];
                    n_window[5] = r_cycle_count[15:8];
                    n_window[6] = r_cycle_count[23:16];
                    n_window[7] = r_cycle_count[31:24];
                end else begin
                    case (wdcl_pkg::t_sub'(r_in_off[1:0]))
                        wdcl_pkg::SUB_STOP: begin
                            n_armed     = 1'b0;
                            n_remaining = '0;
                            n_reload    = '0;
                            n_window[0] = wdcl_pkg::STOP_MARK;
                        end
                        wdcl_pkg::SUB_START: begin
                            n_reload    = {r_in_byte, r_window[2], r_window[1]};
                            n_remaining = {r_in_byte, r_window[2], r_window[1]};
                            n_armed     = 1'b1;
                            n_window[0] = wdcl_pkg::RUN_MARK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // State update, one item per cycle while the result register can take a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wdcl_pkg::WIN_DEPTH; k++) begin
                r_window[k] <= 8'h00;
            end
            r_cycle_count <= '0;
            r_reload      <= '0;
            r_remaining   <= '0;
            r_armed       <= 1'b0;
        end else if (proc_fire) begin
            r_window      <= n_window;
            r_cycle_count <= n_cycle_count;
            r_reload      <= n_reload;
            r_remaining   <= n_remaining;
            r_armed       <= n_armed;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (proc_fire) begin
            r_read_byte <= n_read_byte;
            r_expired   <= n_expired;
            r_running   <= n_armed;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_byte = r_read_byte;
    assign o_expired   = r_expired;
    assign o_running   = r_running;

    // Checks on the countdown and the window.
    `WDCL_ASSERT_NOW(a_expired_stops, i_clk, i_rst_n, o_valid && o_expired, !o_running,
        "expiry reported while still running")
    `WDCL_ASSERT_NOW(a_stopped_zero, i_clk, i_rst_n, !r_armed, r_remaining == '0,
        "remaining count nonzero while stopped")
    `WDCL_ASSERT_NOW(a_byte0_mark, i_clk, i_rst_n, 1'b1,
        r_window[0] == wdcl_pkg::RUN_MARK || r_window[0] == wdcl_pkg::STOP_MARK,
        "window byte 0 holds neither mark")
    `WDCL_ASSERT_NEXT(a_tick_count, i_clk, i_rst_n,
        proc_fire && r_in_mode == wdcl_pkg::MODE_TICK,
        r_cycle_count == $past(r_cycle_count) + 32'd1,
        "cycle count did not advance on a tick")

endmodule
